FILE: hw/rtl/nss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_pkg
// Shared widths, codes and record types of the network segment subdivider.
// ----------------------------------------------------------------------------
package nss_pkg;

   // fixed field widths of the channels
   localparam int VTX_W     = 16;
   localparam int FINE_W    = 20;
   localparam int COARSE_W  = 16;
   localparam int COORD_W   = 32;
   localparam int POS_W     = 17;
   localparam int PIECES_W  = 7;

   // widest counter a parameter may ask for
   localparam int CTR_MAX_W = 32;

   // parameter defaults
   localparam int MAX_PIECES_DEF  = 64;
   localparam int VERTEX_BITS_DEF = 16;
   localparam int FINE_BITS_DEF   = 20;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one in Q1.16
   localparam logic [POS_W-1:0] ONE_Q16 = 17'h10000;

   // input modes and result kinds
   localparam logic MODE_SEGMENT = 1'b0;
   localparam logic MODE_POINT   = 1'b1;
   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_POINT   = 1'b1;

   // classified command from front to back
   typedef struct packed {
      logic                  is_point;
      logic                  error;
      logic [PIECES_W-1:0]   pieces;
      logic [VTX_W-1:0]      from_vtx;
      logic [VTX_W-1:0]      to_vtx;
      logic [COORD_W-1:0]    xs;
      logic [COORD_W-1:0]    ys;
      logic                  dx_neg;
      logic [COORD_W-1:0]    dx_mag;
      logic                  dy_neg;
      logic [COORD_W-1:0]    dy_mag;
      logic [COARSE_W-1:0]   coarse;
      logic [CTR_MAX_W-1:0]  fine;
      logic [CTR_MAX_W-1:0]  vtx;
      logic [POS_W-1:0]      fpos;
   } cmd_type;

   // one result word
   typedef struct packed {
      logic                  kind;
      logic [FINE_W-1:0]     fine_segment;
      logic [VTX_W-1:0]      piece_from;
      logic [VTX_W-1:0]      piece_to;
      logic                  new_vertex_valid;
      logic [COORD_W-1:0]    new_vertex_x;
      logic [COORD_W-1:0]    new_vertex_y;
      logic [COARSE_W-1:0]   coarse_segment;
      logic [POS_W-1:0]      coarse_pos;
      logic [POS_W-1:0]      fine_pos;
      logic                  error;
      logic                  last;
   } rsp_type;

   // back end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } bk_state_type;

endpackage

FILE: hw/rtl/nss_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_req_if
// Input channel: segment and point words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nss_req_if;
   import nss_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [VTX_W-1:0]            from_vertex;
   logic [VTX_W-1:0]            to_vertex;
   logic signed [COORD_W-1:0]   x_start;
   logic signed [COORD_W-1:0]   y_start;
   logic signed [COORD_W-1:0]   x_end;
   logic signed [COORD_W-1:0]   y_end;
   logic [PIECES_W-1:0]         pieces;
   logic [COARSE_W-1:0]         point_segment;
   logic [POS_W-1:0]            point_pos;

   modport source (
      output valid, mode, from_vertex, to_vertex, x_start, y_start, x_end, y_end,
             pieces, point_segment, point_pos,
      input  ready
   );

   modport sink (
      input  valid, mode, from_vertex, to_vertex, x_start, y_start, x_end, y_end,
             pieces, point_segment, point_pos,
      output ready
   );
endinterface

FILE: hw/rtl/nss_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_rsp_if
// Result channel: fine segment and point mapping words, valid/ready.
// ----------------------------------------------------------------------------
interface nss_rsp_if;
   import nss_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [FINE_W-1:0]           fine_segment;
   logic [VTX_W-1:0]            piece_from;
   logic [VTX_W-1:0]            piece_to;
   logic                        new_vertex_valid;
   logic signed [COORD_W-1:0]   new_vertex_x;
   logic signed [COORD_W-1:0]   new_vertex_y;
   logic [COARSE_W-1:0]         coarse_segment;
   logic [POS_W-1:0]            coarse_pos;
   logic [POS_W-1:0]            fine_pos;
   logic                        error;
   logic                        last;

   modport source (
      output valid, kind, fine_segment, piece_from, piece_to, new_vertex_valid,
             new_vertex_x, new_vertex_y, coarse_segment, coarse_pos, fine_pos,
             error, last,
      input  ready
   );

   modport sink (
      input  valid, kind, fine_segment, piece_from, piece_to, new_vertex_valid,
             new_vertex_x, new_vertex_y, coarse_segment, coarse_pos, fine_pos,
             error, last,
      output ready
   );
endinterface

FILE: hw/rtl/nss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_front
// Accepts input words, keeps the segment bookkeeping and turns each word
// into a command: a segment to split, or a finished point mapping.
// ----------------------------------------------------------------------------
module nss_front #(
   parameter int MAX_PIECES  = nss_pkg::MAX_PIECES_DEF,
   parameter int VERTEX_BITS = nss_pkg::VERTEX_BITS_DEF,
   parameter int FINE_BITS   = nss_pkg::FINE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   nss_req_if.sink                       req,
   input  logic                          csr_wr_en,
   input  logic [nss_pkg::VTX_W-1:0]     csr_wr_data,
   output logic                          push_valid,
   input  logic                          push_ready,
   output nss_pkg::cmd_type              push_data
);
   import nss_pkg::*;

   localparam int CNT_W = $clog2(MAX_PIECES + 1);
   localparam int TN_W  = POS_W + CNT_W;

   // bookkeeping registers
   logic [VERTEX_BITS-1:0] vertex_ff, vertex_in;
   logic [FINE_BITS-1:0]   fine_ff, fine_in;
   logic [COARSE_W-1:0]    coarse_ff, coarse_in;
   logic [CNT_W-1:0]       cur_pieces_ff, cur_pieces_in;
   logic [FINE_BITS-1:0]   base_ff, base_in;
   logic                   seen_ff, seen_in;

   logic                   accept;
   logic                   is_seg;
   logic [CNT_W-1:0]       n_sat;
   logic [COORD_W:0]       dx_full, dy_full, dx_negv, dy_negv;
   logic [COARSE_W-1:0]    cur_index;
   logic                   pt_error;
   logic [POS_W-1:0]       t_sat;
   logic [TN_W-1:0]        tn;
   logic [CNT_W:0]         ll_raw, ll;
   logic [FINE_BITS-1:0]   pt_fine;
   logic [POS_W-1:0]       pt_fpos;

   assign req.ready = push_ready;
   assign accept    = req.valid && req.ready;
   assign is_seg    = (req.mode == MODE_SEGMENT);

   // piece count saturation
   always_comb begin
      if (req.pieces > PIECES_W'(MAX_PIECES)) begin
         n_sat = CNT_W'(MAX_PIECES);
      end else begin
         n_sat = CNT_W'(req.pieces);
      end
   end

   // coordinate deltas as sign and magnitude
   always_comb begin
      dx_full = {req.x_end[COORD_W-1], req.x_end} - {req.x_start[COORD_W-1], req.x_start};
      dy_full = {req.y_end[COORD_W-1], req.y_end} - {req.y_start[COORD_W-1], req.y_start};
      dx_negv = '0 - dx_full;
      dy_negv = '0 - dy_full;
   end

   // point mapping against the current segment
   always_comb begin
      cur_index = coarse_ff - COARSE_W'(1);
      pt_error  = !seen_ff || (cur_pieces_ff == '0) || (req.point_segment != cur_index);
      t_sat     = (req.point_pos > ONE_Q16) ? ONE_Q16 : req.point_pos;
      tn        = TN_W'(t_sat) * TN_W'(cur_pieces_ff);
      ll_raw    = tn[TN_W-1:POS_W-1];
      if (ll_raw >= {1'b0, cur_pieces_ff}) begin
         ll = {1'b0, cur_pieces_ff} - (CNT_W+1)'(1);
      end else begin
         ll = ll_raw;
      end
      pt_fine = base_ff + FINE_BITS'(ll);
      pt_fpos = POS_W'(tn - (TN_W'(ll) << (POS_W - 1)));
   end

   // command word
   always_comb begin
      push_data          = '0;
      push_data.is_point = !is_seg;
      if (is_seg) begin
         push_data.pieces   = PIECES_W'(n_sat);
         push_data.from_vtx = req.from_vertex;
         push_data.to_vtx   = req.to_vertex;
         push_data.xs       = req.x_start;
         push_data.ys       = req.y_start;
         push_data.dx_neg   = dx_full[COORD_W];
         push_data.dx_mag   = dx_full[COORD_W] ? dx_negv[COORD_W-1:0] : dx_full[COORD_W-1:0];
         push_data.dy_neg   = dy_full[COORD_W];
         push_data.dy_mag   = dy_full[COORD_W] ? dy_negv[COORD_W-1:0] : dy_full[COORD_W-1:0];
         push_data.coarse   = coarse_ff;
         push_data.fine     = CTR_MAX_W'(fine_ff);
         push_data.vtx      = CTR_MAX_W'(vertex_ff);
      end else begin
         push_data.error = pt_error;
         if (!pt_error) begin
            push_data.fine = CTR_MAX_W'(pt_fine);
            push_data.fpos = pt_fpos;
         end
      end
   end

   // dropped segments update state but send nothing
   assign push_valid = accept && !(is_seg && (n_sat == '0));

   // bookkeeping next values
   always_comb begin
      vertex_in     = vertex_ff;
      fine_in       = fine_ff;
      coarse_in     = coarse_ff;
      cur_pieces_in = cur_pieces_ff;
      base_in       = base_ff;
      seen_in       = seen_ff;
      if (csr_wr_en) begin
         vertex_in = VERTEX_BITS'(csr_wr_data);
      end else if (accept && is_seg) begin
         coarse_in     = coarse_ff + COARSE_W'(1);
         seen_in       = 1'b1;
         cur_pieces_in = n_sat;
         base_in       = fine_ff;
         fine_in       = fine_ff + FINE_BITS'(n_sat);
         if (n_sat != '0) begin
            vertex_in = vertex_ff + VERTEX_BITS'(n_sat) - VERTEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff     <= '0;
         fine_ff       <= '0;
         coarse_ff     <= '0;
         cur_pieces_ff <= '0;
         base_ff       <= '0;
         seen_ff       <= 1'b0;
      end else begin
         vertex_ff     <= vertex_in;
         fine_ff       <= fine_in;
         coarse_ff     <= coarse_in;
         cur_pieces_ff <= cur_pieces_in;
         base_ff       <= base_in;
         seen_ff       <= seen_in;
      end
   end

endmodule

FILE: hw/rtl/nss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
module nss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  nss_pkg::cmd_type  push_data,
   output logic              pop_valid,
   input  logic              pop,
   output nss_pkg::cmd_type  pop_data
);
   import nss_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/nss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_back
// Executes commands: a point goes straight to the output register; a segment
// is divided by its piece count (three bit-serial lanes); remainder-carrying
// accumulators then step out one fine segment word per cycle unless stalled.
// ----------------------------------------------------------------------------
module nss_back #(
   parameter int MAX_PIECES  = nss_pkg::MAX_PIECES_DEF,
   parameter int VERTEX_BITS = nss_pkg::VERTEX_BITS_DEF,
   parameter int FINE_BITS   = nss_pkg::FINE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  nss_pkg::cmd_type  q_data,
   output logic              q_pop,
   nss_rsp_if.source         rsp
);
   import nss_pkg::*;

   localparam int CNT_W  = $clog2(MAX_PIECES + 1);
   localparam int REM_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(COORD_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_W - 1);

   typedef struct packed {
      logic [COORD_W-1:0] quot;
      logic [REM_W-1:0]   rem;
   } lane_type;

   // one restoring division step
   function automatic lane_type lane_step(lane_type l, logic [CNT_W-1:0] n);
      logic [REM_W-1:0] sh;
      lane_type         r;
      sh     = {l.rem[REM_W-2:0], l.quot[COORD_W-1]};
      r.quot = {l.quot[COORD_W-2:0], 1'b0};
      if (sh >= {1'b0, n}) begin
         r.rem     = sh - {1'b0, n};
         r.quot[0] = 1'b1;
      end else begin
         r.rem = sh;
      end
      return r;
   endfunction

   // add one more quotient/remainder pair to an accumulator
   function automatic lane_type acc_step(lane_type acc, lane_type q, logic [CNT_W-1:0] n);
      logic [REM_W-1:0] s;
      logic             carry;
      lane_type         r;
      s     = acc.rem + q.rem;
      carry = (s >= {1'b0, n});
      r.rem  = carry ? (s - {1'b0, n}) : s;
      r.quot = acc.quot + q.quot + COORD_W'(carry);
      return r;
   endfunction

   bk_state_type            state_ff, state_in;
   cmd_type                 cmd_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [CNT_W-1:0]        j_ff;
   logic [STEP_W-1:0]       div_cnt_ff;
   lane_type                divx_ff, divy_ff, divc_ff;
   lane_type                divx_nx, divy_nx, divc_nx;
   lane_type                accx_ff, accy_ff, accc_ff;
   logic [VERTEX_BITS-1:0]  vtx_ff;
   logic [FINE_BITS-1:0]    fine_ff;
   logic [VTX_W-1:0]        prev_ff;
   rsp_type                 rsp_ff, seg_rec, pt_rec;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    out_free;
   logic                    last_piece;
   logic                    seg_start, pt_load, div_run, emit;
   logic [COORD_W-1:0]      x_off, y_off;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign last_piece = (j_ff == n_ff - CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && !q_data.is_point) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (div_cnt_ff == STEP_LAST) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free && last_piece) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      seg_start = 1'b0;
      pt_load   = 1'b0;
      div_run   = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            seg_start = q_valid && !q_data.is_point;
            pt_load   = q_valid && q_data.is_point && out_free;
         end
         BK_DIV:  div_run = 1'b1;
         BK_EMIT: emit    = out_free;
         default: ;
      endcase
      q_pop = seg_start || pt_load;
   end

   // division lanes
   always_comb begin
      divx_nx = lane_step(divx_ff, n_ff);
      divy_nx = lane_step(divy_ff, n_ff);
      divc_nx = lane_step(divc_ff, n_ff);
   end

   // fine segment record
   always_comb begin
      x_off   = cmd_ff.dx_neg ? ('0 - accx_ff.quot) : accx_ff.quot;
      y_off   = cmd_ff.dy_neg ? ('0 - accy_ff.quot) : accy_ff.quot;
      seg_rec = '0;
      seg_rec.kind         = KIND_SEGMENT;
      seg_rec.fine_segment = FINE_W'(fine_ff);
      seg_rec.piece_from   = prev_ff;
      seg_rec.last         = last_piece;
      if (last_piece) begin
         seg_rec.piece_to = cmd_ff.to_vtx;
      end else begin
         seg_rec.piece_to         = VTX_W'(vtx_ff);
         seg_rec.new_vertex_valid = 1'b1;
         seg_rec.new_vertex_x     = cmd_ff.xs + x_off;
         seg_rec.new_vertex_y     = cmd_ff.ys + y_off;
         seg_rec.coarse_segment   = cmd_ff.coarse;
         seg_rec.coarse_pos       = POS_W'(accc_ff.quot);
      end
   end

   // point mapping record
   always_comb begin
      pt_rec              = '0;
      pt_rec.kind         = KIND_POINT;
      pt_rec.fine_segment = FINE_W'(q_data.fine);
      pt_rec.fine_pos     = q_data.fpos;
      pt_rec.error        = q_data.error;
      pt_rec.last         = 1'b1;
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pt_load || emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (seg_start) begin
         cmd_ff       <= q_data;
         n_ff         <= CNT_W'(q_data.pieces);
         j_ff         <= '0;
         div_cnt_ff   <= '0;
         divx_ff.quot <= q_data.dx_mag;
         divx_ff.rem  <= '0;
         divy_ff.quot <= q_data.dy_mag;
         divy_ff.rem  <= '0;
         divc_ff.quot <= COORD_W'(ONE_Q16);
         divc_ff.rem  <= '0;
         vtx_ff       <= VERTEX_BITS'(q_data.vtx);
         fine_ff      <= FINE_BITS'(q_data.fine);
         prev_ff      <= q_data.from_vtx;
      end
      if (div_run) begin
         div_cnt_ff <= div_cnt_ff + STEP_W'(1);
         divx_ff    <= divx_nx;
         divy_ff    <= divy_nx;
         divc_ff    <= divc_nx;
         accx_ff    <= divx_nx;
         accy_ff    <= divy_nx;
         accc_ff    <= divc_nx;
      end
      if (emit) begin
         j_ff    <= j_ff + CNT_W'(1);
         fine_ff <= fine_ff + FINE_BITS'(1);
         accx_ff <= acc_step(accx_ff, divx_ff, n_ff);
         accy_ff <= acc_step(accy_ff, divy_ff, n_ff);
         accc_ff <= acc_step(accc_ff, divc_ff, n_ff);
         if (!last_piece) begin
            vtx_ff  <= vtx_ff + VERTEX_BITS'(1);
            prev_ff <= VTX_W'(vtx_ff);
         end
      end
      if (pt_load) begin
         rsp_ff <= pt_rec;
      end else if (emit) begin
         rsp_ff <= seg_rec;
      end
   end

   // result channel
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.kind             = rsp_ff.kind;
   assign rsp.fine_segment     = rsp_ff.fine_segment;
   assign rsp.piece_from       = rsp_ff.piece_from;
   assign rsp.piece_to         = rsp_ff.piece_to;
   assign rsp.new_vertex_valid = rsp_ff.new_vertex_valid;
   assign rsp.new_vertex_x     = rsp_ff.new_vertex_x;
   assign rsp.new_vertex_y     = rsp_ff.new_vertex_y;
   assign rsp.coarse_segment   = rsp_ff.coarse_segment;
   assign rsp.coarse_pos       = rsp_ff.coarse_pos;
   assign rsp.fine_pos         = rsp_ff.fine_pos;
   assign rsp.error            = rsp_ff.error;
   assign rsp.last             = rsp_ff.last;

`ifndef SYNTHESIS
   // commands are only taken while the sequencer is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("queue popped while back end busy");

   // division always hands over to the emit phase
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && div_cnt_ff == STEP_LAST) |=> (state_ff == BK_EMIT))
      else $error("division did not finish into emit");

   // piece index stays below the piece count
   a_piece_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) |-> (j_ff < n_ff))
      else $error("piece index out of range");

   // accumulator remainders stay reduced
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) |-> ((accx_ff.rem < {1'b0, n_ff}) &&
                                 (accy_ff.rem < {1'b0, n_ff}) &&
                                 (accc_ff.rem < {1'b0, n_ff})))
      else $error("accumulator remainder not reduced");
`endif

endmodule

FILE: hw/rtl/network_segment_subdivider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_segment_subdivider
// Splits network segments into equal fine pieces and maps points onto them.
//
//   channel   | direction | handshake           | word
//   ----------+-----------+---------------------+------------------------------
//   req_ch    | in        | valid/ready         | segment or point word
//   rsp_ch    | out       | valid/ready         | fine segment or point record
//   csr_*     | in        | write enable only   | initial vertex count
//
// A segment of n pieces holds the back end to take the command, divide by n
// bit-serially and send one word per cycle unless the output stalls. A point
// goes straight to the output register; a dropped segment never leaves the
// front, which keeps accepting into a two-entry queue while the back end works.
// Reset is synchronous, active high; an output stall holds the back end.
// ----------------------------------------------------------------------------
module network_segment_subdivider #(
   parameter int MAX_PIECES  = nss_pkg::MAX_PIECES_DEF,
   parameter int VERTEX_BITS = nss_pkg::VERTEX_BITS_DEF,
   parameter int FINE_BITS   = nss_pkg::FINE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   nss_req_if.sink                      req_ch,
   nss_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [nss_pkg::VTX_W-1:0]    csr_wr_data
);
   import nss_pkg::*;

   logic     push_valid, push_ready;
   cmd_type  push_data;
   logic     pop_valid, pop;
   cmd_type  pop_data;

   // classification and bookkeeping
   nss_front #(
      .MAX_PIECES  (MAX_PIECES),
      .VERTEX_BITS (VERTEX_BITS),
      .FINE_BITS   (FINE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // command queue
   nss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   // execution and output register
   nss_back #(
      .MAX_PIECES  (MAX_PIECES),
      .VERTEX_BITS (VERTEX_BITS),
      .FINE_BITS   (FINE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_ch)
   );

endmodule

FILE: test/network_segment_subdivider_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_segment_subdivider_tb
// Self-checking bench for the segment subdivider. Segment and point words are
// sent with random gaps while the result side stalls at random. Every accepted
// word runs through an in-bench model of the subdivision and point mapping.
// Each result record is compared field by field with the oldest expected one.
// Directed cases come first, then a long output hold-off, then random traffic
// under three vertex base settings.
// ----------------------------------------------------------------------------
module network_segment_subdivider_tb;
   import nss_pkg::*;

   localparam int          MAX_N        = MAX_PIECES_DEF;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SETTLE_CYCLES = 50;

   // one input word as the bench builds it
   typedef struct packed {
      logic                mode;
      logic [VTX_W-1:0]    from_v;
      logic [VTX_W-1:0]    to_v;
      logic [COORD_W-1:0]  xs;
      logic [COORD_W-1:0]  ys;
      logic [COORD_W-1:0]  xe;
      logic [COORD_W-1:0]  ye;
      logic [PIECES_W-1:0] pieces;
      logic [COARSE_W-1:0] pseg;
      logic [POS_W-1:0]    ppos;
   } req_word_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [VTX_W-1:0] csr_wr_data;

   nss_req_if req_ch ();
   nss_rsp_if rsp_ch ();

   network_segment_subdivider dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // model state of the subdivider
   logic [VTX_W-1:0]    vtx_ctr    = '0;
   logic [FINE_W-1:0]   fine_ctr   = '0;
   logic [COARSE_W-1:0] coarse_ctr = '0;
   logic [PIECES_W-1:0] cur_pieces = '0;
   logic [FINE_W-1:0]   cur_base   = '0;
   logic                seg_seen   = 1'b0;

   rsp_type records_due[$];

   // traffic control shared by the driver and the result sink
   logic quiet        = 1'b0;
   logic hold_trigger = 1'b0;

   int unsigned fail_count   = 0;
   int unsigned words_sent   = 0;
   int unsigned n_segments   = 0;
   int unsigned n_dropped    = 0;
   int unsigned n_points     = 0;
   int unsigned n_off_points = 0;
   int unsigned n_checked    = 0;
   int unsigned n_bases      = 0;

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // start + trunc(j * (end - start) / n), division toward zero
   function automatic logic [COORD_W-1:0] lerp_coord(input logic [COORD_W-1:0] s,
                                                     input logic [COORD_W-1:0] e,
                                                     input int unsigned j,
                                                     input int unsigned n);
      longint a;
      longint d;
      longint q;
      a = longint'($signed(s));
      d = longint'($signed(e)) - a;
      q = (longint'(j) * d) / longint'(n);
      return COORD_W'(a + q);
   endfunction

   // model: records caused by one accepted word
   task automatic subdivide_and_map(input req_word_type w);
      rsp_type             rec;
      logic [PIECES_W-1:0] n;
      logic [VTX_W-1:0]    prev;
      logic [COARSE_W-1:0] c;
      logic [POS_W-1:0]    t;
      logic [23:0]         tn;
      logic [7:0]          ll;
      int unsigned         j;
      if (w.mode == MODE_SEGMENT) begin
         n = (w.pieces > MAX_N) ? PIECES_W'(MAX_N) : w.pieces;
         c = coarse_ctr;
         prev = w.from_v;
         coarse_ctr = coarse_ctr + 1'b1;
         seg_seen = 1'b1;
         cur_pieces = n;
         cur_base = fine_ctr;
         n_segments++;
         if (n == 0)
            n_dropped++;
         for (j = 1; j <= n; j++) begin
            rec = '0;
            rec.kind = KIND_SEGMENT;
            rec.fine_segment = fine_ctr;
            rec.piece_from = prev;
            if (j < n) begin
               rec.piece_to = vtx_ctr;
               rec.new_vertex_valid = 1'b1;
               rec.new_vertex_x = lerp_coord(w.xs, w.xe, j, 32'(n));
               rec.new_vertex_y = lerp_coord(w.ys, w.ye, j, 32'(n));
               rec.coarse_segment = c;
               rec.coarse_pos = POS_W'((j << 16) / n);
               prev = vtx_ctr;
               vtx_ctr = vtx_ctr + 1'b1;
            end else begin
               rec.piece_to = w.to_v;
               rec.last = 1'b1;
            end
            records_due.push_back(rec);
            fine_ctr = fine_ctr + 1'b1;
         end
      end else begin
         rec = '0;
         rec.kind = KIND_POINT;
         rec.last = 1'b1;
         n_points++;
         if (!seg_seen || cur_pieces == 0 || w.pseg != COARSE_W'(coarse_ctr - 1'b1)) begin
            rec.error = 1'b1;
            n_off_points++;
         end else begin
            t = (w.ppos > ONE_Q16) ? ONE_Q16 : w.ppos;
            tn = t * cur_pieces;
            ll = tn[23:16];
            // point at the far end goes onto the last piece
            if (ll >= cur_pieces)
               ll = 8'(cur_pieces) - 8'd1;
            rec.fine_segment = cur_base + FINE_W'(ll);
            rec.fine_pos = POS_W'(tn - (24'(ll) << 16));
         end
         records_due.push_back(rec);
      end
   endtask

   // word builders, unused fields get random filler
   function automatic req_word_type segment_word(input logic [VTX_W-1:0] from_v,
                                                 input logic [VTX_W-1:0] to_v,
                                                 input logic [COORD_W-1:0] xs,
                                                 input logic [COORD_W-1:0] ys,
                                                 input logic [COORD_W-1:0] xe,
                                                 input logic [COORD_W-1:0] ye,
                                                 input logic [PIECES_W-1:0] n);
      req_word_type w;
      w.mode = MODE_SEGMENT;
      w.from_v = from_v;
      w.to_v = to_v;
      w.xs = xs;
      w.ys = ys;
      w.xe = xe;
      w.ye = ye;
      w.pieces = n;
      w.pseg = COARSE_W'($urandom);
      w.ppos = POS_W'($urandom);
      return w;
   endfunction

   function automatic req_word_type random_segment(input logic [PIECES_W-1:0] n);
      return segment_word(VTX_W'($urandom), VTX_W'($urandom), $urandom, $urandom,
                          $urandom, $urandom, n);
   endfunction

   function automatic req_word_type point_word(input logic [COARSE_W-1:0] seg,
                                               input logic [POS_W-1:0] pos);
      req_word_type w;
      w = random_segment(PIECES_W'($urandom));
      w.mode = MODE_POINT;
      w.pseg = seg;
      w.ppos = pos;
      return w;
   endfunction

   // mostly small piece counts, a few drops and saturating counts
   function automatic logic [PIECES_W-1:0] pick_pieces();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6)
         return '0;
      else if (r < 12)
         return PIECES_W'($urandom_range(MAX_N + 1, 127));
      else if (r < 18)
         return PIECES_W'($urandom_range(17, MAX_N));
      return PIECES_W'($urandom_range(1, 8));
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      case ($urandom_range(9))
         0: return '0;
         1: return ONE_Q16;
         2: return ONE_Q16 - 1'b1;
         3: return POS_W'($urandom_range(65537, 131071));
         default: return POS_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // send one word, with random idle cycles ahead of it unless quiet is set
   task automatic send_word(input req_word_type w);
      while (!quiet && $urandom_range(99) < 19) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.mode          <= w.mode;
      req_ch.from_vertex   <= w.from_v;
      req_ch.to_vertex     <= w.to_v;
      req_ch.x_start       <= w.xs;
      req_ch.y_start       <= w.ys;
      req_ch.x_end         <= w.xe;
      req_ch.y_end         <= w.ye;
      req_ch.pieces        <= w.pieces;
      req_ch.point_segment <= w.pseg;
      req_ch.point_pos     <= w.ppos;
      do
         @(posedge clock);
      while (!req_ch.ready);
      words_sent++;
      subdivide_and_map(w);
   endtask

   // wait for every expected record, then let the block settle
   task automatic wait_drained(input int unsigned settle);
      req_ch.valid <= 1'b0;
      while (records_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // vertex base write, only while the block is idle
   task automatic load_vertex_base(input logic [VTX_W-1:0] value);
      wait_drained(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vtx_ctr = value;
      n_bases++;
   endtask

   // field extremes, drops, clamps, saturation and off-segment points
   task automatic test_directed_cases();
      send_word(point_word(16'd0, 17'd100));
      send_word(segment_word(16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 7'd1));
      send_word(point_word(16'd0, 17'd0));
      send_word(point_word(16'd0, ONE_Q16));
      send_word(point_word(16'd0, 17'h1FFFF));
      send_word(point_word(16'd1, 17'd100));
      send_word(segment_word(16'h1234, 16'h4321, 32'd0, 32'd0, 32'd0, 32'd0, 7'd0));
      send_word(point_word(16'd1, 17'd30000));
      send_word(segment_word(16'hFFFF, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h8000_0000, 7'd64));
      send_word(point_word(16'd2, ONE_Q16));
      send_word(point_word(16'd2, 17'd0));
      send_word(point_word(16'd2, 17'd1023));
      send_word(point_word(16'd2, 17'd65535));
      send_word(random_segment(7'd127));
      send_word(point_word(16'd3, 17'h1FFFF));
      // negative deltas check truncation toward zero
      send_word(segment_word(16'd7, 16'd9, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFB,
                             32'd4, 7'd3));
      send_word(point_word(16'd4, 17'd21845));
      send_word(point_word(16'd3, 17'd100));
      // vertex counter wraps inside one segment
      load_vertex_base(16'hFFFD);
      send_word(random_segment(7'd7));
      send_word(point_word(16'd5, 17'd40000));
      load_vertex_base(16'hFFFF);
      send_word(random_segment(7'd2));
      send_word(point_word(16'd6, 17'd32768));
   endtask

   // result side holds off while words keep coming, so the input stalls
   task automatic test_output_stall();
      int unsigned k;
      wait_drained(SETTLE_CYCLES);
      hold_trigger <= ~hold_trigger;
      quiet <= 1'b1;
      for (k = 0; k < 12; k++) begin
         if (k % 3 == 2)
            send_word(point_word(COARSE_W'(coarse_ctr - 1'b1), pick_pos()));
         else
            send_word(random_segment(PIECES_W'($urandom_range(2, 6))));
      end
      quiet <= 1'b0;
   endtask

   // segments followed by their points, mixed with stray points and drops
   task automatic test_random_traffic(input logic [VTX_W-1:0] base,
                                      input logic no_idle,
                                      input int unsigned word_target);
      int unsigned start_count;
      int unsigned k;
      int unsigned npts;
      load_vertex_base(base);
      quiet <= no_idle;
      start_count = words_sent;
      while (words_sent - start_count < word_target) begin
         if ($urandom_range(99) < 80) begin
            send_word(random_segment(pick_pieces()));
            npts = $urandom_range(0, 4);
            for (k = 0; k < npts; k++)
               send_word(point_word(COARSE_W'(coarse_ctr - 1'b1), pick_pos()));
         end else begin
            case ($urandom_range(2))
               0: send_word(point_word(COARSE_W'($urandom), pick_pos()));
               1: begin
                  send_word(random_segment(7'd0));
                  send_word(point_word(COARSE_W'(coarse_ctr - 1'b1), pick_pos()));
               end
               default: send_word(point_word(COARSE_W'(coarse_ctr - 2'd2), pick_pos()));
            endcase
         end
      end
      wait_drained(0);
      quiet <= 1'b0;
   endtask

   // result sink: random stalls, a counted hold-off on request
   initial begin : rsp_sink
      int unsigned hold_left;
      logic        hold_ack;
      hold_left = 0;
      hold_ack = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger != hold_ack) begin
            hold_ack = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 19);
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: record %0d %s expected %h actual %h",
                  $time, n_checked, name, want, got);
         fail_count++;
      end
   endfunction

   // compare each accepted record with the oldest expected one
   always @(posedge clock) begin : record_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind             = rsp_ch.kind;
         got.fine_segment     = rsp_ch.fine_segment;
         got.piece_from       = rsp_ch.piece_from;
         got.piece_to         = rsp_ch.piece_to;
         got.new_vertex_valid = rsp_ch.new_vertex_valid;
         got.new_vertex_x     = rsp_ch.new_vertex_x;
         got.new_vertex_y     = rsp_ch.new_vertex_y;
         got.coarse_segment   = rsp_ch.coarse_segment;
         got.coarse_pos       = rsp_ch.coarse_pos;
         got.fine_pos         = rsp_ch.fine_pos;
         got.error            = rsp_ch.error;
         got.last             = rsp_ch.last;
         if (records_due.size() == 0) begin
            $display("%0t ns: unexpected record, expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = records_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(got.kind));
            check_field("fine_segment", 32'(want.fine_segment), 32'(got.fine_segment));
            check_field("piece_from", 32'(want.piece_from), 32'(got.piece_from));
            check_field("piece_to", 32'(want.piece_to), 32'(got.piece_to));
            check_field("new_vertex_valid", 32'(want.new_vertex_valid),
                        32'(got.new_vertex_valid));
            check_field("new_vertex_x", want.new_vertex_x, got.new_vertex_x);
            check_field("new_vertex_y", want.new_vertex_y, got.new_vertex_y);
            check_field("coarse_segment", 32'(want.coarse_segment),
                        32'(got.coarse_segment));
            check_field("coarse_pos", 32'(want.coarse_pos), 32'(got.coarse_pos));
            check_field("fine_pos", 32'(want.fine_pos), 32'(got.fine_pos));
            check_field("error", 32'(want.error), 32'(got.error));
            check_field("last", 32'(want.last), 32'(got.last));
         end
         n_checked++;
      end
   end

   // run limit
   initial begin : run_limit
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   // test sequence
   initial begin : run_tests
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_SEGMENT;
      req_ch.from_vertex   = '0;
      req_ch.to_vertex     = '0;
      req_ch.x_start       = '0;
      req_ch.y_start       = '0;
      req_ch.x_end         = '0;
      req_ch.y_end         = '0;
      req_ch.pieces        = '0;
      req_ch.point_segment = '0;
      req_ch.point_pos     = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_output_stall();
      test_random_traffic(VTX_W'($urandom), 1'b0, 85);
      test_random_traffic(16'h0000, 1'b1, 80);
      test_random_traffic(16'hFFF0, 1'b0, 85);

      wait_drained(60);
      $display("covered %0d segment words (%0d dropped), %0d point words (%0d off-segment)",
               n_segments, n_dropped, n_points, n_off_points);
      $display("checked %0d records over %0d vertex base settings, %0d mismatches",
               n_checked, n_bases, fail_count);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/nss_pkg.sv
hw/rtl/nss_req_if.sv
hw/rtl/nss_rsp_if.sv
hw/rtl/nss_front.sv
hw/rtl/nss_queue.sv
hw/rtl/nss_back.sv
hw/rtl/network_segment_subdivider.sv
test/network_segment_subdivider_tb.sv
